FILE: hdl/ols_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg: shared types and codes for the ordered list store
// Request and response payloads, request kinds, status codes and the
// command set that the top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package ols_pkg;

	// request kinds
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_ERASE      = 3'd4;
	localparam logic [2:0] REQ_INSERT     = 3'd5;

	// response status
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_BADPOS = 2'd1;
	localparam logic [1:0] STS_EMPTY  = 2'd2;
	localparam logic [1:0] STS_FULL   = 2'd3;

	// cell commands
	localparam logic [2:0] OP_HOLD       = 3'd0;
	localparam logic [2:0] OP_INSERT     = 3'd1; // open a slot at sel, load value
	localparam logic [2:0] OP_SHIFT_DOWN = 3'd2; // every cell takes its upper neighbor
	localparam logic [2:0] OP_MARK       = 3'd3; // flag matches and unused cells as holes
	localparam logic [2:0] OP_BUBBLE     = 3'd4; // one compaction step

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         entry_count;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [6:0]         removed_count;
	} rsp_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} ctl_t;

endpackage
`default_nettype wire

FILE: hdl/ols_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface ols_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ols_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_cell: one slot of the list
// Holds one value and a hole flag; trades data with its two neighbors.
// ----------------------------------------------------------------------------
module ols_cell import ols_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  logic [CNT_W-1:0]   sel,
	input  logic signed [31:0] prev_value,
	input  logic               prev_hole,
	input  logic signed [31:0] next_value,
	input  logic               next_hole,
	output logic signed [31:0] value,
	output logic               hole
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [31:0] val_q;
	logic               hole_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (MY_IDX > sel) begin
					val_q <= prev_value;
				end else if (MY_IDX == sel) begin
					val_q <= ctl.value;
				end
			end
			OP_SHIFT_DOWN: begin
				val_q <= next_value;
			end
			OP_BUBBLE: begin
				if (hole_q && !next_hole) begin
					val_q <= next_value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_MARK: begin
					hole_q <= (MY_IDX >= sel) || (val_q == ctl.value);
				end
				OP_BUBBLE: begin
					// a hole swaps with a filled upper neighbor
					if (hole_q && !next_hole) begin
						hole_q <= 1'b0;
					end else if (!hole_q && prev_hole) begin
						hole_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign value = val_q;
	assign hole  = hole_q;

endmodule
`default_nettype wire

FILE: hdl/ordered_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list of signed 32-bit values
// Push/pop at either end, insert before a position, erase all matches.
// Sequence: push, pop, insert and refused requests go from idle to the report
//   state and then to the response register; an erase marks holes, runs its
//   compaction steps (none when no holes must move) and then reports.
// Throughput: one request at a time; a new request is taken only when idle.
// Reset: count, state, hole flags and response valid clear at once; cell
//   contents are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_store import ols_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	ols_stream_if.sink   req,
	ols_stream_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ERASE  = 2'd1;
	localparam logic [1:0] S_REPORT = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] removed_q, removed_d;
	logic [1:0]       status_q, status_d;
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;

	// broadcast to the cell row
	ctl_t             ctl;
	logic [CNT_W-1:0] sel;

	// row taps
	logic signed [31:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] hole_vec;
	logic [CAPACITY-1:0] hole_prev;
	logic [CAPACITY-1:0] hole_next;
	logic [CAPACITY-1:0] swap_vec;
	logic [CAPACITY-1:0] first_vec;
	logic [CNT_W-1:0]    first_idx;

	logic req_acc;
	logic full;
	logic empty;
	logic rsp_free;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [IDX_W-1:0] back_idx;
	logic signed [31:0] front_val;
	logic signed [31:0] back_val;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign pos_ext   = CMP_W'(req.data.position);
	assign cnt_ext   = CMP_W'(count_q);

	// ------------------------------------------------------------------
	// Cell row. Cell 0 is the front. Ends see an empty neighbor below and a
	// hole above, so nothing moves past either end.
	// ------------------------------------------------------------------
	assign hole_prev = {hole_vec[CAPACITY-2:0], 1'b0};
	assign hole_next = {1'b1, hole_vec[CAPACITY-1:1]};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] pv;
		logic signed [31:0] nv;
		if (i == 0) begin : g_lo
			assign pv = '0;
		end else begin : g_mid_lo
			assign pv = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign nv = '0;
		end else begin : g_mid_hi
			assign nv = cell_val[i+1];
		end
		ols_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (sel),
			.prev_value (pv),
			.prev_hole  (hole_prev[i]),
			.next_value (nv),
			.next_hole  (hole_next[i]),
			.value      (cell_val[i]),
			.hole       (hole_vec[i])
		);
	end

	// Erase runs as bubble compaction: holes move toward the back by
	// neighbor swaps until they form a suffix. Then the first hole marks
	// the new count.
	assign swap_vec  = hole_vec & ~hole_next;
	assign first_vec = hole_vec & ~hole_prev;

	always_comb begin
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				first_idx = first_idx | CNT_W'(i);
			end
		end
		// full list with no match leaves no hole at all
		if (hole_vec == '0) begin
			first_idx = count_q;
		end
	end

	// ------------------------------------------------------------------
	// Request decode and sequencing
	// ------------------------------------------------------------------
	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.value = req.data.value;
		sel       = count_q;
		count_d   = count_q;
		status_d  = status_q;
		removed_d = removed_q;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					status_d  = STS_OK;
					removed_d = '0;
					state_d   = S_REPORT;
					case (req.data.req_type)
						REQ_PUSH_BACK: begin
							if (full) begin
								status_d = STS_FULL;
							end else begin
								ctl.op  = OP_INSERT;
								sel     = count_q;
								count_d = count_q + 1'b1;
							end
						end
						REQ_PUSH_FRONT: begin
							if (full) begin
								status_d = STS_FULL;
							end else begin
								ctl.op  = OP_INSERT;
								sel     = '0;
								count_d = count_q + 1'b1;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								status_d = STS_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								status_d = STS_EMPTY;
							end else begin
								ctl.op  = OP_SHIFT_DOWN;
								count_d = count_q - 1'b1;
							end
						end
						REQ_ERASE: begin
							ctl.op  = OP_MARK;
							sel     = count_q;
							state_d = S_ERASE;
						end
						REQ_INSERT: begin
							// fullness wins over a bad position
							if (full) begin
								status_d = STS_FULL;
							end else if (pos_ext > cnt_ext) begin
								status_d = STS_BADPOS;
							end else begin
								ctl.op  = OP_INSERT;
								sel     = CNT_W'(req.data.position);
								count_d = count_q + 1'b1;
							end
						end
						default: begin
							// unknown kind: no change, status ok
						end
					endcase
				end
			end
			S_ERASE: begin
				if (|swap_vec) begin
					ctl.op = OP_BUBBLE;
				end else begin
					count_d   = first_idx;
					removed_d = count_q - first_idx;
					state_d   = S_REPORT;
				end
			end
			S_REPORT: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			status_q  <= STS_OK;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
			status_q  <= status_d;
		end
	end

	// ------------------------------------------------------------------
	// Response register. Front and back are read from the row in the report
	// state, after the update has reached the cells.
	// ------------------------------------------------------------------
	assign back_idx  = IDX_W'(count_q - 1'b1);
	assign front_val = empty ? 32'sd0 : cell_val[0];
	assign back_val  = empty ? 32'sd0 : cell_val[back_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_REPORT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPORT && rsp_free) begin
			rsp_data_q.status        <= status_q;
			rsp_data_q.entry_count   <= 7'(count_q);
			rsp_data_q.front_value   <= front_val;
			rsp_data_q.back_value    <= back_val;
			rsp_data_q.removed_count <= 7'(removed_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.data.req_type != REQ_ERASE) |=> (state_q == S_REPORT))
		else $error("non-erase request did not go straight to report");

	a_erase_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERASE && swap_vec == '0)
		|=> (count_q + removed_q == $past(count_q)))
		else $error("erase lost track of entries");

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPORT && rsp_valid_q && !rsp.ready) |=> (state_q == S_REPORT))
		else $error("response dropped while output stalled");

endmodule
`default_nettype wire

FILE: tb/ols_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_list_checker: response predictor and comparator for ordered_list_store
// Watches both channels. Every request transaction updates a private model
// of the list and queues the expected response; every response transaction
// is compared, field by field, with the oldest queued response.
// ----------------------------------------------------------------------------
module ols_list_checker import ols_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	output int   fail_count,
	output int   pending
);

	logic signed [31:0] list_values[$];   // modeled list, front first
	rsp_t               awaited_rsp[$];   // expected responses, oldest first

	// Apply one request to the modeled list and return its response.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t               o;
		logic [1:0]         st;
		int unsigned        removed;
		logic signed [31:0] kept[$];
		st      = STS_OK;
		removed = 0;
		case (r.req_type)
			REQ_PUSH_BACK: begin
				if (list_values.size() >= CAPACITY) st = STS_FULL;
				else list_values.push_back(r.value);
			end
			REQ_PUSH_FRONT: begin
				if (list_values.size() >= CAPACITY) st = STS_FULL;
				else list_values.push_front(r.value);
			end
			REQ_POP_BACK: begin
				if (list_values.size() == 0) st = STS_EMPTY;
				else void'(list_values.pop_back());
			end
			REQ_POP_FRONT: begin
				if (list_values.size() == 0) st = STS_EMPTY;
				else void'(list_values.pop_front());
			end
			REQ_ERASE: begin
				foreach (list_values[i]) begin
					if (list_values[i] == r.value) removed++;
					else kept.push_back(list_values[i]);
				end
				list_values = kept;
			end
			REQ_INSERT: begin
				// fullness wins over a bad position
				if (list_values.size() >= CAPACITY) st = STS_FULL;
				else if (int'(r.position) > list_values.size()) st = STS_BADPOS;
				else list_values.insert(int'(r.position), r.value);
			end
			default: ; // unknown kinds leave the list alone
		endcase
		o.status        = st;
		o.entry_count   = 7'(list_values.size());
		o.front_value   = (list_values.size() == 0) ? '0 : list_values[0];
		o.back_value    = (list_values.size() == 0) ? '0 : list_values[$];
		o.removed_count = 7'(removed);
		return o;
	endfunction

	task automatic check_field(input string fname, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_values.delete();
			awaited_rsp.delete();
			fail_count = 0;
			pending   <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response transaction with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("status", want.status, rsp_data.status);
					check_field("entry_count", want.entry_count, rsp_data.entry_count);
					check_field("front_value", want.front_value, rsp_data.front_value);
					check_field("back_value", want.back_value, rsp_data.back_value);
					check_field("removed_count", want.removed_count, rsp_data.removed_count);
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(apply_request(req_data));
			pending <= awaited_rsp.size();
		end
	end

endmodule

FILE: tb/tb_ordered_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_store: self-checking bench for ordered_list_store
// A directed opener hits empty-list, unknown-kind and end-of-list corners,
// then phases of random requests push the list toward full, drain it or
// hammer erase with a small value pool. The sender bursts, the receiver
// stalls; ols_list_checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_ordered_list_store;
	import ols_pkg::*;

	localparam int LIST_DEPTH   = 64;
	localparam int RANDOM_ITEMS = 1430;
	// Worst legal quiet stretch is an erase over a full list plus a long
	// sender gap and a receiver stall; this is many times that.
	localparam int STALL_LIMIT  = 2000;
	// Drain time after the last response: longest erase compaction and margin.
	localparam int TAIL_CYCLES  = 2 * LIST_DEPTH + 16;

	// request kinds the block does not define
	localparam logic [2:0] REQ_UNKNOWN_A = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN_B = 3'd7;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_ERASE} mix_t;
	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	int   burst_left  = 0;

	ols_stream_if #(.T(req_t)) req_ch ();
	ols_stream_if #(.T(rsp_t)) rsp_ch ();

	ordered_list_store #(.CAPACITY(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ols_list_checker #(.CAPACITY(LIST_DEPTH)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_data   (req_ch.data),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_data   (rsp_ch.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Receiver: ready follows a randomly drawn mode, each held for a random span:
	// always on, coin flip, a fixed periodic stall pattern, or long random stalls.
	// ------------------------------------------------------------------------
	rx_mode_t rx_mode      = RX_ALWAYS;
	int       rx_mode_left = 0;
	int       rx_phase     = 0;
	int       rx_hold      = 0;
	logic     rx_stalled   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_mode_left = 0;
			rx_hold      = 0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 300);
				rx_hold      = 0;
			end
			rx_mode_left--;
			rx_phase = (rx_phase + 1) % 7;
			case (rx_mode)
				RX_ALWAYS:   rsp_ch.ready <= 1'b1;
				RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: rsp_ch.ready <= (rx_phase > 1);
				RX_LONG: begin
					if (rx_hold == 0) begin
						rx_stalled = !rx_stalled;
						rx_hold    = rx_stalled ? $urandom_range(4, 16) : $urandom_range(1, 6);
					end
					rx_hold--;
					rsp_ch.ready <= !rx_stalled;
				end
				default:     rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any accepted transaction on either channel resets the count.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("** ordered_list_store: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic req_t make_req(input logic [2:0] kind, input logic signed [31:0] val,
			input logic [6:0] pos);
		req_t r;
		r.req_type = kind;
		r.value    = val;
		r.position = pos;
		return r;
	endfunction

	// Random request shaped by the phase mix: grow and shrink weights set
	// where the count drifts; the erase mix draws values from a tiny pool so
	// erases remove many entries at once.
	function automatic req_t random_request(input mix_t mix);
		req_t r;
		int   grow;
		int   shrink;
		int   roll;
		int   vroll;
		case (mix)
			MIX_FILL:  begin grow = 80; shrink = 10; end
			MIX_DRAIN: begin grow = 25; shrink = 65; end
			MIX_ERASE: begin grow = 55; shrink = 10; end
			default:   begin grow = 45; shrink = 40; end
		endcase
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0) begin
			r.req_type = $urandom_range(0, 1) ? REQ_UNKNOWN_A : REQ_UNKNOWN_B;
		end else if (roll < grow) begin
			case ($urandom_range(0, 2))
				0:       r.req_type = REQ_PUSH_BACK;
				1:       r.req_type = REQ_PUSH_FRONT;
				default: r.req_type = REQ_INSERT;
			endcase
		end else if (roll < grow + shrink) begin
			r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
		end else begin
			r.req_type = REQ_ERASE;
		end

		vroll = $urandom_range(0, 99);
		if ((mix == MIX_ERASE && vroll < 80) || vroll < 35)
			r.value = 32'(int'($urandom_range(0, 3)) - 1);   // pool: -1..2
		else if (vroll < 45)
			r.value = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		else
			r.value = $urandom;

		// mostly in or just past the legal range, sometimes anywhere
		roll = $urandom_range(0, 9);
		if (roll < 7)      r.position = 7'($urandom_range(0, LIST_DEPTH + 2));
		else if (roll < 9) r.position = 7'($urandom_range(0, 3));
		else               r.position = 7'($urandom_range(0, 127));
		return r;
	endfunction

	// Present one request and hold it until the transaction completes. Bursts
	// of random length are separated by random gaps; now and then a long
	// burst runs with no gaps at all.
	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(60, 150);
			else burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		req_ch.data  <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	initial begin
		req_t r;
		mix_t mix;
		int   sent;
		int   phase_len;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// --- directed corners ---------------------------------------------
		send_request(make_req(REQ_POP_BACK, 32'sd0, 7'd0));          // empty pop
		send_request(make_req(REQ_POP_FRONT, 32'sd0, 7'd0));
		send_request(make_req(REQ_ERASE, 32'sd0, 7'd0));             // erase on empty
		send_request(make_req(REQ_UNKNOWN_A, 32'shffff_ffff, 7'h7f));
		send_request(make_req(REQ_UNKNOWN_B, 32'sh8000_0000, 7'd0));
		send_request(make_req(REQ_INSERT, 32'sd9, 7'd1));            // bad position
		send_request(make_req(REQ_INSERT, 32'sh7fff_ffff, 7'd0));    // insert into empty
		send_request(make_req(REQ_POP_FRONT, 32'sd0, 7'd0));         // front pop to empty
		send_request(make_req(REQ_PUSH_BACK, 32'sd5, 7'd0));
		send_request(make_req(REQ_INSERT, -32'sd1, 7'd1));           // append to one entry
		send_request(make_req(REQ_INSERT, 32'sd3, 7'h7f));           // far past the end
		send_request(make_req(REQ_PUSH_FRONT, 32'sh8000_0000, 7'd0));
		send_request(make_req(REQ_INSERT, 32'sd0, 7'd1));
		send_request(make_req(REQ_PUSH_BACK, -32'sd1, 7'd0));
		send_request(make_req(REQ_ERASE, 32'sd77, 7'd0));            // no match
		send_request(make_req(REQ_ERASE, -32'sd1, 7'd0));            // two matches
		send_request(make_req(REQ_POP_BACK, 32'sd0, 7'd0));
		send_request(make_req(REQ_POP_FRONT, 32'sd0, 7'd0));
		send_request(make_req(REQ_ERASE, 32'sd5, 7'd0));             // erase leaves one entry

		// --- random phases --------------------------------------------------
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mix       = mix_t'($urandom_range(0, 3));
			phase_len = $urandom_range(40, 120);
			repeat (phase_len) begin
				if (sent < RANDOM_ITEMS) begin
					r = random_request(mix);
					send_request(r);
					sent++;
				end
			end
		end

		// --- drain ---------------------------------------------------------
		// pending is a registered copy of the checker's queue size, so step the clock before polling
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("** ordered_list_store: PASSED **");
		else
			$display("** ordered_list_store: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hdl/ols_pkg.sv
hdl/ols_stream_if.sv
hdl/ols_cell.sv
hdl/ordered_list_store.sv
tb/ols_list_checker.sv
tb/tb_ordered_list_store.sv
